>>> src/zfg_pkg.sv
// Package for the Zernike field-gain block: widths, register indexes, reset values,
// fixed-point constants, payload and configuration types and the Q16 rounding function.
// Depends on nothing.
package zfg_pkg;

  localparam int MAX_IMAGE_DIM = 4096;

  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int WGT_W      = 24;
  localparam int SMP_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int OFS_W = 15;
  localparam int SQ_W  = 30;
  localparam int NUM_W = 48;
  localparam int MAG_W = 46;
  localparam int DIV_W = 27;
  localparam int QUO_W = 32;
  localparam int RR_W  = 2 * DIM_W - 1;
  localparam int PRD_W = WGT_W + SMP_W;
  localparam int ACC_W = PRD_W + 3;
  localparam int TERMS = 5;

  localparam int GEOM_LAT   = 5;
  localparam int DIV_LAT    = QUO_W + 2;
  localparam int COMB_LAT   = 7;
  localparam int PIPE_LAT   = GEOM_LAT + DIV_LAT + COMB_LAT;
  localparam int SAMPLE_TAP = GEOM_LAT + DIV_LAT + 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PISTON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TILT_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TILT_B   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OBLIQUE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DEFOCUS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ASTIG    = 3'd7;

  localparam logic [DIM_W-1:0]        RST_DIM        = 13'd256;
  localparam logic signed [WGT_W-1:0] RST_PISTON     = 24'sd65536;
  localparam logic signed [WGT_W-1:0] RST_TILT       = 24'sd6554;
  localparam logic signed [WGT_W-1:0] RST_ZERO       = 24'sd0;

  localparam logic signed [18:0] SQRT6_Q16 = 19'sd160530;
  localparam logic signed [18:0] SQRT3_Q16 = 19'sd113512;

  typedef struct packed {
    logic [POS_W-1:0]        pixel_col;
    logic [POS_W-1:0]        pixel_row;
    logic signed [SMP_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic signed [SMP_W-1:0] field_gain;
    logic                    outside_image;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0]  wc;
    logic [DIM_W-1:0]  hc;
    logic [DIM_W-1:0]  r;
    logic [RR_W-1:0]   rr;
    logic [RR_W:0]     rr2;
    logic [RR_W+1:0]   rr4;
  } geo_t;

  typedef struct packed {
    logic signed [WGT_W-1:0] piston;
    logic signed [WGT_W-1:0] tilt_a;
    logic signed [WGT_W-1:0] tilt_b;
    logic signed [WGT_W-1:0] oblique_astig;
    logic signed [WGT_W-1:0] defocus;
    logic signed [WGT_W-1:0] astig;
  } wgt_t;

  // Divides by 65536 rounding to nearest, ties away from zero, and saturates to 32 bits.
  function automatic logic signed [SMP_W-1:0] sat_q16(input logic signed [63:0] v);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] q;
    logic signed [SMP_W-1:0] res;
    neg = v[63];
    mag = neg ? 64'(-v) : 64'(v);
    q   = (mag + 64'd32768) >> 16;
    if (!neg && q > 64'd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (neg && q > 64'd2147483648) begin
      res = 32'sh80000000;
    end else if (neg) begin
      res = 32'(-q);
    end else begin
      res = 32'(q);
    end
    return res;
  endfunction

endpackage

>>> src/zfg_cfg.sv
// Configuration registers of the field-gain block and the derived geometry
// (clamped size, radius, its square and that square doubled and quadrupled). Depends on zfg_pkg.
module zfg_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [zfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zfg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output zfg_pkg::geo_t                  geo,
  output zfg_pkg::wgt_t                  wgt
);
  import zfg_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  wgt_t             wgt_r;
  logic [DIM_W-1:0] wc_nxt;
  logic [DIM_W-1:0] hc_nxt;
  logic [DIM_W-1:0] r_r;
  logic [RR_W-1:0]  rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r             <= RST_DIM;
      height_r            <= RST_DIM;
      wgt_r.piston        <= RST_PISTON;
      wgt_r.tilt_a        <= RST_TILT;
      wgt_r.tilt_b        <= RST_TILT;
      wgt_r.oblique_astig <= RST_ZERO;
      wgt_r.defocus       <= RST_ZERO;
      wgt_r.astig         <= RST_ZERO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    width_r             <= DIM_W'(cfg_wdata);
        REG_IMAGE_HEIGHT:   height_r            <= DIM_W'(cfg_wdata);
        REG_WEIGHT_PISTON:  wgt_r.piston        <= cfg_wdata;
        REG_WEIGHT_TILT_A:  wgt_r.tilt_a        <= cfg_wdata;
        REG_WEIGHT_TILT_B:  wgt_r.tilt_b        <= cfg_wdata;
        REG_WEIGHT_OBLIQUE: wgt_r.oblique_astig <= cfg_wdata;
        REG_WEIGHT_DEFOCUS: wgt_r.defocus       <= cfg_wdata;
        REG_WEIGHT_ASTIG:   wgt_r.astig         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      wc_nxt = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_IMAGE_DIM)) begin
      wc_nxt = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      wc_nxt = width_r;
    end
    if (height_r == '0) begin
      hc_nxt = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_IMAGE_DIM)) begin
      hc_nxt = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      hc_nxt = height_r;
    end
  end

  always_ff @(posedge clk) begin
    r_r  <= (wc_nxt > hc_nxt) ? wc_nxt : hc_nxt;
    rr_r <= RR_W'(r_r) * RR_W'(r_r);
  end

  assign geo.wc  = wc_nxt;
  assign geo.hc  = hc_nxt;
  assign geo.r   = r_r;
  assign geo.rr  = rr_r;
  assign geo.rr2 = {rr_r, 1'b0};
  assign geo.rr4 = {rr_r, 2'b00};
  assign wgt     = wgt_r;

endmodule

>>> src/zfg_geom.sv
// Geometry front end: doubled offsets, their products, the five term numerators and
// their rounded magnitudes ready for division. Five register stages. Depends on zfg_pkg.
module zfg_geom (
  input  logic                     clk,
  input  logic                     en,
  input  logic [zfg_pkg::POS_W-1:0] pixel_col,
  input  logic [zfg_pkg::POS_W-1:0] pixel_row,
  input  zfg_pkg::geo_t            geo,
  output logic [zfg_pkg::MAG_W-1:0] mag_r [zfg_pkg::TERMS],
  output logic                     neg_r [zfg_pkg::TERMS]
);
  import zfg_pkg::*;

  logic signed [OFS_W-1:0] dx_r;
  logic signed [OFS_W-1:0] dy_r;
  logic signed [OFS_W-1:0] dx2_r;
  logic signed [OFS_W-1:0] dy2_r;
  logic signed [SQ_W-1:0]  sqx_r;
  logic signed [SQ_W-1:0]  sqy_r;
  logic signed [SQ_W-1:0]  xy_r;
  logic signed [SQ_W-1:0]  x4_r;
  logic signed [SQ_W-1:0]  x5_r;
  logic signed [SQ_W-1:0]  xy3_r;
  logic signed [NUM_W-1:0] n1_r;
  logic signed [NUM_W-1:0] n2_r;
  logic signed [NUM_W-1:0] num_r [TERMS];
  logic [MAG_W-1:0]        half [TERMS];

  always_comb begin
    half[0] = MAG_W'(geo.r >> 1);
    half[1] = MAG_W'(geo.r >> 1);
    half[2] = MAG_W'(geo.rr);
    half[3] = MAG_W'(geo.rr);
    half[4] = MAG_W'(geo.rr2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= $signed({2'b00, pixel_col, 1'b0} - {2'b00, geo.wc});
      dy_r   <= $signed({2'b00, pixel_row, 1'b0} - {2'b00, geo.hc});

      sqx_r  <= SQ_W'(dx_r) * SQ_W'(dx_r);
      sqy_r  <= SQ_W'(dy_r) * SQ_W'(dy_r);
      xy_r   <= SQ_W'(dx_r) * SQ_W'(dy_r);
      dx2_r  <= dx_r;
      dy2_r  <= dy_r;

      x4_r   <= sqx_r + sqy_r - $signed({{(SQ_W-RR_W-1){1'b0}}, geo.rr2});
      x5_r   <= sqy_r - sqx_r;
      xy3_r  <= xy_r;
      n1_r   <= NUM_W'(dx2_r) <<< 16;
      n2_r   <= NUM_W'(dy2_r) <<< 16;

      num_r[0] <= n1_r;
      num_r[1] <= n2_r;
      num_r[2] <= NUM_W'(SQRT6_Q16) * NUM_W'(xy3_r);
      num_r[3] <= NUM_W'(SQRT3_Q16) * NUM_W'(x4_r);
      num_r[4] <= NUM_W'(SQRT6_Q16) * NUM_W'(x5_r);

      for (int i = 0; i < TERMS; i++) begin
        neg_r[i] <= num_r[i][NUM_W-1];
        mag_r[i] <= MAG_W'(num_r[i][NUM_W-1] ? -num_r[i] : num_r[i]) + half[i];
      end
    end
  end

endmodule

>>> src/zfg_rdiv.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detection and
// signed 32-bit saturation of the rounded quotient. Depends on zfg_pkg.
module zfg_rdiv (
  input  logic                      clk,
  input  logic                      en,
  input  logic [zfg_pkg::MAG_W-1:0] mag,
  input  logic                      neg,
  input  logic [zfg_pkg::DIV_W-1:0] den,
  output logic signed [zfg_pkg::SMP_W-1:0] quo_r
);
  import zfg_pkg::*;

  logic [DIV_W-1:0] rem_r [QUO_W+1];
  logic [QUO_W-1:0] lo_r  [QUO_W+1];
  logic [QUO_W-1:0] q_r   [QUO_W+1];
  logic             neg_r [QUO_W+1];
  logic             ovf_r [QUO_W+1];
  logic [QUO_W-1:0] q_fin;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DIV_W'(mag[MAG_W-1:QUO_W]);
      ovf_r[0] <= DIV_W'(mag[MAG_W-1:QUO_W]) >= den;
      lo_r[0]  <= mag[QUO_W-1:0];
      q_r[0]   <= '0;
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DIV_W:0] trial;
    logic           take;
    assign trial = {rem_r[k], lo_r[k][QUO_W-1]};
    assign take  = trial >= {1'b0, den};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? DIV_W'(trial - {1'b0, den}) : DIV_W'(trial);
        q_r[k+1]   <= {q_r[k][QUO_W-2:0], take};
        lo_r[k+1]  <= {lo_r[k][QUO_W-2:0], 1'b0};
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign q_fin = q_r[QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QUO_W]) begin
        if (ovf_r[QUO_W] || q_fin > 32'h80000000) begin
          quo_r <= 32'sh80000000;
        end else begin
          quo_r <= $signed(-q_fin);
        end
      end else begin
        if (ovf_r[QUO_W] || q_fin[QUO_W-1]) begin
          quo_r <= 32'sh7FFFFFFF;
        end else begin
          quo_r <= $signed(q_fin);
        end
      end
    end
  end

endmodule

>>> src/zfg_comb.sv
// Back end: weights the Zernike terms, sums them into the field gain and applies the gain
// to the sample, with Q16 rounding and saturation. Seven register stages. Depends on zfg_pkg.
module zfg_comb (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [zfg_pkg::SMP_W-1:0] term [zfg_pkg::TERMS],
  input  zfg_pkg::wgt_t                    wgt,
  input  logic signed [zfg_pkg::SMP_W-1:0] sample,
  output logic signed [zfg_pkg::SMP_W-1:0] prod_r,
  output logic signed [zfg_pkg::SMP_W-1:0] gain_r
);
  import zfg_pkg::*;

  logic signed [PRD_W-1:0] p_r [6];
  logic signed [PRD_W:0]   s_r [3];
  logic signed [PRD_W+1:0] s01_r;
  logic signed [PRD_W+1:0] s2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [SMP_W-1:0] gain5_r;
  logic signed [SMP_W-1:0] gain6_r;
  logic signed [63:0]      full_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PRD_W'(wgt.piston) <<< 16;
      p_r[1] <= PRD_W'(wgt.tilt_a) * PRD_W'(term[0]);
      p_r[2] <= PRD_W'(wgt.tilt_b) * PRD_W'(term[1]);
      p_r[3] <= PRD_W'(wgt.oblique_astig) * PRD_W'(term[2]);
      p_r[4] <= PRD_W'(wgt.defocus) * PRD_W'(term[3]);
      p_r[5] <= PRD_W'(wgt.astig) * PRD_W'(term[4]);

      s_r[0] <= (PRD_W+1)'(p_r[0]) + (PRD_W+1)'(p_r[1]);
      s_r[1] <= (PRD_W+1)'(p_r[2]) + (PRD_W+1)'(p_r[3]);
      s_r[2] <= (PRD_W+1)'(p_r[4]) + (PRD_W+1)'(p_r[5]);

      s01_r  <= (PRD_W+2)'(s_r[0]) + (PRD_W+2)'(s_r[1]);
      s2_r   <= (PRD_W+2)'(s_r[2]);

      acc_r  <= ACC_W'(s01_r) + ACC_W'(s2_r);

      gain5_r <= sat_q16(64'(acc_r));

      full_r  <= 64'(sample) * 64'(gain5_r);
      gain6_r <= gain5_r;

      prod_r  <= sat_q16(full_r);
      gain_r  <= gain6_r;
    end
  end

endmodule

>>> src/zernike_field_gain_apply.sv
// Top level of the Zernike order-2 field-gain block: configuration, geometry front end,
// five term dividers, weighting back end and output skid buffer.
// Depends on zfg_pkg, zfg_cfg, zfg_geom, zfg_rdiv and zfg_comb.
//
//  Port group  Direction  Handshake         Payload
//  in_*        input      in_valid/in_stall  in_t  (pixel_col, pixel_row, sample_in)
//  out_*       output     out_valid/out_stall out_t (sample_out, field_gain, outside_image)
//  cfg_*       input      cfg_we             cfg_index, cfg_wdata
//
// One transaction is taken every cycle while in_stall is low; each result passes through
// the geometry front end, the 32 quotient-bit stages of the term dividers and the back end.
// The whole pipeline advances together. A result that arrives while the output register
// still waits is parked in a skid register, and the pipeline and in_stall then hold until
// the waiting result is taken.
// Reset is synchronous and active low and clears valid bits and configuration only.
module zernike_field_gain_apply (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  zfg_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output zfg_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [zfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zfg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import zfg_pkg::*;

  typedef struct packed {
    logic                    valid;
    logic                    outside;
    logic signed [SMP_W-1:0] sample;
  } sb_t;

  geo_t                    geo;
  wgt_t                    wgt;
  logic                    en;
  sb_t                     sb_r [PIPE_LAT];
  logic [MAG_W-1:0]        mag [TERMS];
  logic                    neg [TERMS];
  logic [DIV_W-1:0]        den [TERMS];
  logic signed [SMP_W-1:0] term [TERMS];
  logic signed [SMP_W-1:0] prod;
  logic signed [SMP_W-1:0] gain;
  out_t                    res;
  logic                    res_valid;
  logic                    out_valid_r;
  out_t                    out_data_r;
  logic                    skid_full_r;
  out_t                    skid_data_r;

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  zfg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geo       (geo),
    .wgt       (wgt)
  );

  zfg_geom u_geom (
    .clk       (clk),
    .en        (en),
    .pixel_col (in_data.pixel_col),
    .pixel_row (in_data.pixel_row),
    .geo       (geo),
    .mag_r     (mag),
    .neg_r     (neg)
  );

  always_comb begin
    den[0] = DIV_W'(geo.r);
    den[1] = DIV_W'(geo.r);
    den[2] = DIV_W'(geo.rr2);
    den[3] = DIV_W'(geo.rr2);
    den[4] = DIV_W'(geo.rr4);
  end

  for (genvar t = 0; t < TERMS; t++) begin : g_div
    zfg_rdiv u_rdiv (
      .clk   (clk),
      .en    (en),
      .mag   (mag[t]),
      .neg   (neg[t]),
      .den   (den[t]),
      .quo_r (term[t])
    );
  end

  zfg_comb u_comb (
    .clk    (clk),
    .en     (en),
    .term   (term),
    .wgt    (wgt),
    .sample (sb_r[SAMPLE_TAP].sample),
    .prod_r (prod),
    .gain_r (gain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        sb_r[i].valid <= 1'b0;
      end
    end else if (en) begin
      sb_r[0].valid   <= in_valid;
      sb_r[0].outside <= ({1'b0, in_data.pixel_col} >= geo.wc) ||
                         ({1'b0, in_data.pixel_row} >= geo.hc);
      sb_r[0].sample  <= in_data.sample_in;
      for (int i = 1; i < PIPE_LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  assign res_valid         = sb_r[PIPE_LAT-1].valid;
  assign res.sample_out    = prod;
  assign res.field_gain    = gain;
  assign res.outside_image = sb_r[PIPE_LAT-1].outside;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (en && res_valid) begin
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else begin
        skid_full_r <= 1'b1;
        skid_data_r <= res;
      end
    end else if (out_valid_r && !out_stall) begin
      if (skid_full_r) begin
        out_data_r  <= skid_data_r;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
